// ===== rtl/core/ras_pkg.sv =====
// Shared types and constants for the ring all-reduce slice schedule.
// Used by ras_ctrl, ras_dp and ring_allreduce_slice_schedule.
package ras_pkg;

  localparam int GRID_W  = 31;
  localparam int ELEM_W  = 31;
  localparam int RC_W    = 20;
  localparam int BYTES_W = 22;
  localparam int GW      = 12;
  localparam int DIV_N   = 32;
  localparam int CFG_W   = 31;
  localparam int IDX_W   = 3;
  localparam int CHUNK_SHIFT = 19;

  localparam logic [RC_W-1:0]   CHUNK_ELEMS = 20'd524288;
  localparam logic [RC_W-1:0]   MIN_SLICE   = 20'd8192;
  localparam logic [GRID_W-1:0] GRID_MAX    = 31'h7FFF_FFFF;
  localparam logic [10:0]       THREAD_FLOOR = 11'd32;

  localparam logic [IDX_W-1:0] REG_RANK_COUNT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [IDX_W-1:0] REG_CHANNEL_INDEX = 3'd2;
  localparam logic [IDX_W-1:0] REG_MY_RANK       = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIRECTION     = 3'd4;
  localparam logic [IDX_W-1:0] REG_THREAD_COUNT  = 3'd5;
  localparam logic [IDX_W-1:0] REG_ELEMENT_COUNT = 3'd6;

  localparam logic [1:0] DIV_RANK    = 2'd0;
  localparam logic [1:0] DIV_SPAN    = 2'd1;
  localparam logic [1:0] DIV_GRANULE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_RDIV, ST_ADVANCE, ST_CHECK, ST_QDIV,
    ST_GDIV, ST_CHUNK, ST_MUL, ST_CLAMP, ST_SLICE, ST_EMIT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       second;
    logic       div_start;
    logic [1:0] div_sel;
    logic       r_load;
    logic       advance;
    logic       exhaust;
    logic       exhaust_fin;
    logic       round_load;
    logic       chunk;
    logic       mul;
    logic       clamp;
    logic       slice;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic second_half;
    logic r_valid;
    logic div_done;
    logic step_zero;
    logic grid_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/ring_allreduce_slice_schedule.sv =====
// Top level of the ring all-reduce slice schedule: controller plus datapath.
// Depends on ras_pkg, ras_ctrl, ras_dp (which holds ras_div).
//
// Usage: each transfer on the req channel (req_valid high, req_stall low)
// asks for the next slice of one channel's schedule; restart=1 begins the
// schedule again. Each request yields one transfer on the rsp channel with
// slice_bytes, last_slice and exhausted. Registers are written through
// cfg_write/cfg_index/cfg_data while no request is in flight.
// A second-half slice or a reply on a finished schedule goes straight to the output
// stage. A first-half slice and the exhausted reply that ends a schedule first pass
// through the advance and check states, after a ring position division when the
// position must be recomputed after reset or a register write, and a first-half slice
// also needs the chunk span and thread granule divisions at the start of each grid
// iteration, all on the shared restoring divider.
// req_stall is high from acceptance until the result is loaded into the output
// register, so the next request is accepted only then. The output register lets
// the next request be accepted while a result waits; if rsp_stall stays high the
// block holds the next result until the register frees.
// Reset (rst, synchronous) restores register defaults and an empty schedule.
module ring_allreduce_slice_schedule #(
  parameter int MAX_RANKS    = 64,
  parameter int MAX_CHANNELS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ras_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ras_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        restart,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [ras_pkg::BYTES_W-1:0] slice_bytes,
  output logic                        last_slice,
  output logic                        exhausted
);
  import ras_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ras_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ras_dp #(
    .MAX_RANKS    (MAX_RANKS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .restart     (restart),
    .cmd         (cmd),
    .sts         (sts),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .slice_bytes (slice_bytes),
    .last_slice  (last_slice),
    .exhausted   (exhausted)
  );
endmodule

// ===== rtl/core/ras_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Standalone; no package dependency.
module ras_div #(
  parameter int N = 32,
  parameter int D = 18
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quot,
  output logic [D-1:0] rem
);
  localparam int CNW = $clog2(N + 1);

  logic           busy;
  logic [CNW-1:0] cnt;
  logic [D-1:0]   dvs;
  logic [D:0]     trial;

  assign trial = {rem, quot[N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(N);
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem  <= D'(trial - {1'b0, dvs});
          quot <= {quot[N-2:0], 1'b1};
        end else begin
          rem  <= trial[D-1:0];
          quot <= {quot[N-2:0], 1'b0};
        end
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/ras_ctrl.sv =====
// Sequencing state machine for the slice schedule.
// Depends on ras_pkg; drives cmd_t to ras_dp and reads sts_t back.
module ras_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output ras_pkg::cmd_t cmd,
  input  ras_pkg::sts_t sts
);
  import ras_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.second = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel = DIV_RANK;
    cmd.r_load = 1'b0;
    cmd.advance = 1'b0;
    cmd.exhaust = 1'b0;
    cmd.exhaust_fin = 1'b0;
    cmd.round_load = 1'b0;
    cmd.chunk = 1'b0;
    cmd.mul = 1'b0;
    cmd.clamp = 1'b0;
    cmd.slice = 1'b0;
    cmd.emit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.finished) begin
          cmd.exhaust = 1'b1;
          state_next = ST_EMIT;
        end else if (sts.second_half) begin
          cmd.second = 1'b1;
          state_next = ST_EMIT;
        end else if (!sts.r_valid) begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_RANK;
          state_next = ST_RDIV;
        end else begin
          state_next = ST_ADVANCE;
        end
      end
      ST_RDIV: begin
        if (sts.div_done) begin
          cmd.r_load = 1'b1;
          state_next = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        cmd.advance = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.step_zero) begin
          state_next = ST_CHUNK;
        end else if (sts.grid_done) begin
          cmd.exhaust_fin = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_SPAN;
          state_next = ST_QDIV;
        end
      end
      ST_QDIV: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_GRANULE;
          state_next = ST_GDIV;
        end
      end
      ST_GDIV: begin
        if (sts.div_done) begin
          cmd.round_load = 1'b1;
          state_next = ST_CHUNK;
        end
      end
      ST_CHUNK: begin
        cmd.chunk = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_next = ST_SLICE;
      end
      ST_SLICE: begin
        cmd.slice = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/core/ras_dp.sv =====
// Datapath: configuration registers, schedule state, chunk arithmetic, output register.
// Depends on ras_pkg and ras_div; commanded by ras_ctrl.
module ras_dp #(
  parameter int MAX_RANKS    = 64,
  parameter int MAX_CHANNELS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ras_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ras_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        restart,
  input  ras_pkg::cmd_t               cmd,
  output ras_pkg::sts_t               sts,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [ras_pkg::BYTES_W-1:0] slice_bytes,
  output logic                        last_slice,
  output logic                        exhausted
);
  import ras_pkg::*;

  localparam int KW   = $clog2(MAX_RANKS + 1);
  localparam int CW   = $clog2(MAX_CHANNELS + 1);
  localparam int RW   = (KW > 7) ? KW : 7;
  localparam int CCW  = (CW > 6) ? CW : 6;
  localparam int QW   = CW + KW;
  localparam int D    = (QW > GW) ? QW : GW;
  localparam int LW   = QW + CHUNK_SHIFT;
  localparam int SUMW = ((LW > GRID_W) ? LW : GRID_W) + 1;
  localparam int SW   = KW + 1;
  localparam int TW   = KW + 2;
  localparam int IW   = 5 + KW + 1;
  localparam int PW   = IW + RC_W;
  localparam int OW   = PW + 2;

  logic [6:0]        rank_count;
  logic [5:0]        channel_count;
  logic [4:0]        channel_index;
  logic [5:0]        my_rank;
  logic              direction;
  logic [10:0]       thread_count;
  logic [ELEM_W-1:0] element_count;

  logic [GRID_W-1:0]  grid_offset;
  logic [RC_W-1:0]    rounded_chunk;
  logic [SW-1:0]      step_index;
  logic               second_half;
  logic [BYTES_W-1:0] pending_second;
  logic               finished;
  logic [KW-1:0]      ring_pos;
  logic               r_valid;
  logic [IW-1:0]      idx;
  logic [PW-1:0]      prod;
  logic [RC_W-1:0]    nval;
  logic [BYTES_W-1:0] res_bytes;
  logic               res_last;
  logic               res_exh;

  logic [KW-1:0]      k;
  logic [CW-1:0]      ch;
  logic [QW-1:0]      q;
  logic [GW-1:0]      g;
  logic [SW-1:0]      nsteps;
  logic [SW-1:0]      step_inc;
  logic [SUMW-1:0]    grid_sum;
  logic [GRID_W-1:0]  grid_sat;
  logic [DIV_N-1:0]   div_dividend;
  logic [D-1:0]       div_divisor;
  logic               div_done;
  logic [DIV_N-1:0]   quot;
  logic [D-1:0]       rem;
  logic [RC_W-1:0]    cmin;
  logic [RC_W+GW:0]   rmul;
  logic [TW-1:0]      t_raw;
  logic [TW-1:0]      t_mod;
  logic signed [OW-1:0] n_s;
  logic [RC_W:0]      n_up;
  logic [RC_W-1:0]    sl;
  logic [RC_W-1:0]    slm;
  logic [RC_W-1:0]    first;
  logic [RC_W-1:0]    second;

  always_comb begin
    if (RW'(rank_count) < RW'(2)) begin
      k = KW'(2);
    end else if (RW'(rank_count) > RW'(MAX_RANKS)) begin
      k = KW'(MAX_RANKS);
    end else begin
      k = KW'(rank_count);
    end
    if (channel_count == 6'd0) begin
      ch = CW'(1);
    end else if (CCW'(channel_count) > CCW'(MAX_CHANNELS)) begin
      ch = CW'(MAX_CHANNELS);
    end else begin
      ch = CW'(channel_count);
    end
  end

  assign q        = QW'(ch) * QW'(k);
  assign g        = (thread_count > THREAD_FLOOR) ?
                    GW'({1'b0, thread_count - THREAD_FLOOR} << 1) : GW'(1);
  assign nsteps   = (SW'(k) << 1) - SW'(2);
  assign step_inc = step_index + SW'(1);
  assign grid_sum = SUMW'(grid_offset) + SUMW'(LW'(q) << CHUNK_SHIFT);
  assign grid_sat = (grid_sum > SUMW'(GRID_MAX)) ? GRID_MAX : grid_sum[GRID_W-1:0];

  assign cmin = (quot > DIV_N'(CHUNK_ELEMS)) ? CHUNK_ELEMS : quot[RC_W-1:0];

  always_comb begin
    case (cmd.div_sel)
      DIV_SPAN: begin
        div_dividend = DIV_N'(element_count - grid_offset) + DIV_N'(q) - DIV_N'(1);
        div_divisor  = D'(q);
      end
      DIV_GRANULE: begin
        div_dividend = DIV_N'(cmin) + DIV_N'(g) - DIV_N'(1);
        div_divisor  = D'(g);
      end
      default: begin
        div_dividend = DIV_N'({1'b0, my_rank} + 7'(direction));
        div_divisor  = D'(k);
      end
    endcase
  end

  ras_div #(.N(DIV_N), .D(D)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign rmul = quot[RC_W:0] * g;

  always_comb begin
    if (step_index < SW'(k)) begin
      t_raw = TW'(ring_pos) + TW'(k) - TW'(1) - TW'(step_index);
    end else begin
      t_raw = TW'(ring_pos) + (TW'(k) << 1) - TW'(1) - TW'(step_index);
    end
    t_mod = (t_raw >= TW'(k)) ? t_raw - TW'(k) : t_raw;
  end

  assign n_s = $signed(OW'(element_count)) - $signed(OW'(grid_offset) + OW'(prod));

  assign n_up   = {1'b0, nval} + (RC_W + 1)'(31);
  assign sl     = {n_up[RC_W:5], 4'b0000};
  assign slm    = (sl < MIN_SLICE) ? MIN_SLICE : sl;
  assign first  = (nval < slm) ? nval : slm;
  assign second = (nval > slm) ? nval - slm : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count     <= 7'd2;
      channel_count  <= 6'd1;
      channel_index  <= 5'd0;
      my_rank        <= 6'd0;
      direction      <= 1'b0;
      thread_count   <= 11'd512;
      element_count  <= '0;
      grid_offset    <= '0;
      rounded_chunk  <= '0;
      step_index     <= '0;
      second_half    <= 1'b0;
      pending_second <= '0;
      finished       <= 1'b0;
      r_valid        <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        r_valid <= 1'b0;
        unique case (cfg_index)
          REG_RANK_COUNT:    rank_count    <= cfg_data[6:0];
          REG_CHANNEL_COUNT: channel_count <= cfg_data[5:0];
          REG_CHANNEL_INDEX: channel_index <= cfg_data[4:0];
          REG_MY_RANK:       my_rank       <= cfg_data[5:0];
          REG_DIRECTION:     direction     <= cfg_data[0];
          REG_THREAD_COUNT:  thread_count  <= cfg_data[10:0];
          REG_ELEMENT_COUNT: element_count <= cfg_data[ELEM_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && restart) begin
        grid_offset    <= '0;
        step_index     <= '0;
        second_half    <= 1'b0;
        pending_second <= '0;
        finished       <= 1'b0;
      end
      if (cmd.second) begin
        second_half <= 1'b0;
        res_bytes   <= pending_second;
        res_exh     <= 1'b0;
        if (step_inc >= nsteps) begin
          step_index  <= '0;
          grid_offset <= grid_sat;
          res_last    <= (grid_sat >= element_count);
          if (grid_sat >= element_count) begin
            finished <= 1'b1;
          end
        end else begin
          step_index <= step_inc;
          res_last   <= 1'b0;
        end
      end
      if (cmd.r_load) begin
        ring_pos <= rem[KW-1:0];
        r_valid  <= 1'b1;
      end
      if (cmd.advance && step_index >= nsteps) begin
        step_index  <= '0;
        grid_offset <= grid_sat;
      end
      if (cmd.exhaust || cmd.exhaust_fin) begin
        res_bytes <= '0;
        res_last  <= 1'b0;
        res_exh   <= 1'b1;
      end
      if (cmd.exhaust_fin) begin
        finished <= 1'b1;
      end
      if (cmd.round_load) begin
        rounded_chunk <= rmul[RC_W-1:0];
      end
      if (cmd.chunk) begin
        idx <= IW'(channel_index) * IW'(k) + IW'(t_mod);
      end
      if (cmd.mul) begin
        prod <= PW'(idx) * PW'(rounded_chunk);
      end
      if (cmd.clamp) begin
        if (n_s <= 0) begin
          nval <= '0;
        end else if (n_s > $signed(OW'(rounded_chunk))) begin
          nval <= rounded_chunk;
        end else begin
          nval <= n_s[RC_W-1:0];
        end
      end
      if (cmd.slice) begin
        res_bytes      <= {first, 2'b00};
        res_last       <= 1'b0;
        res_exh        <= 1'b0;
        pending_second <= {second, 2'b00};
        second_half    <= 1'b1;
      end
      if (cmd.emit) begin
        rsp_valid   <= 1'b1;
        slice_bytes <= res_bytes;
        last_slice  <= res_last;
        exhausted   <= res_exh;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign sts.finished    = finished;
  assign sts.second_half = second_half;
  assign sts.r_valid     = r_valid;
  assign sts.div_done    = div_done;
  assign sts.step_zero   = (step_index == '0);
  assign sts.grid_done   = (grid_offset >= element_count);
  assign sts.out_free    = !rsp_valid || !rsp_stall;
endmodule
